/* src/wrs_pkg.sv */
// ----------------------------------------------------------------------------
// wrs_pkg
// types and constants shared by the weighted running statistics block
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 32;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] sample;
        logic        [31:0] weight;
        logic               invalid;
    } wrs_in_t;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic               range_known;
        logic signed [31:0] mean_value;
        logic        [31:0] std_dev;
        logic        [47:0] weight_total;
        logic        [31:0] sample_count;
    } wrs_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MDIV,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_VDIV,
        ST_SQRT,
        ST_OUT
    } wrs_state_t;

endpackage

/* src/weighted_running_statistics.sv */
// clear, invalid or zero-weight add beats go straight to the variance divide;
// a weighted add first runs the multiplies and the mean divide
// one beat is in flight at a time; the work is dominated by the bit-serial 128/48
// variance divide (128 steps), the 64-bit square root (32 steps) and the serial multiplies
// the next beat is taken only once the result register is empty or being read
// reset: rst_n asynchronous active low clears all statistics and the count
// ----------------------------------------------------------------------------
// weighted_running_statistics
// weighted welford mean and variance with min, max, weight total and count,
// multiplies, divides and square root done one bit per cycle
// ----------------------------------------------------------------------------
module weighted_running_statistics (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wrs_pkg::wrs_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wrs_pkg::wrs_out_t  out_data
);

    localparam int F2 = 2 * wrs_pkg::FRAC_BITS;

    wrs_pkg::wrs_state_t state_reg, state_next;

    logic signed [31:0] least_reg, greatest_reg, mean_reg;
    logic               seen_reg;
    logic        [63:0] dev_reg;
    logic        [47:0] wsum_reg, wold_reg;
    logic [wrs_pkg::COUNT_BITS-1:0] cnt_reg;

    logic        [31:0] w_reg;
    logic               neg_reg;
    logic        [32:0] qmag_reg;
    logic        [31:0] rmag_reg;
    logic        [7:0]  step_reg;

    // shared serial multiply/divide datapath registers
    logic        [127:0] acc_reg;
    logic        [127:0] mcand_reg;
    logic        [127:0] shf_reg;
    logic        [48:0]  rem_reg;
    logic        [63:0]  quo_reg;
    logic                over_reg;
    logic        [63:0]  sq_v_reg, sq_res_reg, sq_bit_reg;

    logic out_valid_reg;
    wrs_pkg::wrs_out_t out_reg;

    logic        accept;
    logic [48:0] wsum_add;
    logic [32:0] qmag_c;
    logic signed [32:0] q_c;
    logic [48:0] rem_sh;
    logic [64:0] inc_full;
    logic [63:0] inc_c;
    logic [64:0] dev_add;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == wrs_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign wsum_add = {1'b0, wsum_reg} + {17'd0, in_data.weight};
    assign q_c      = {in_data.sample[31], in_data.sample} - {mean_reg[31], mean_reg};
    assign qmag_c   = q_c[32] ? 33'(-q_c) : 33'(q_c);
    assign rem_sh   = {rem_reg[47:0], shf_reg[127]};

    // product in acc_reg is rmag*qmag*W (up to 112 bits)
    assign inc_full = {1'b0, acc_reg[F2 +: 64]};
    always_comb
    begin
        if (acc_reg[127:F2+64] != '0)
            inc_c = '1;
        else
            inc_c = inc_full[63:0];
    end
    assign dev_add = {1'b0, dev_reg} + {1'b0, inc_c};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wrs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrs_pkg::ST_IDLE:
                if (accept)
                begin
                    if (in_data.cmd == wrs_pkg::CMD_ADD && !in_data.invalid
                        && in_data.weight != '0)
                        state_next = wrs_pkg::ST_MUL1;
                    else
                        state_next = wrs_pkg::ST_VDIV;
                end
            wrs_pkg::ST_MUL1: if (step_reg == 8'd32) state_next = wrs_pkg::ST_MDIV;
            wrs_pkg::ST_MDIV: if (step_reg == 8'd65) state_next = wrs_pkg::ST_MUL2;
            wrs_pkg::ST_MUL2: if (step_reg == 8'd81) state_next = wrs_pkg::ST_ACC;
            wrs_pkg::ST_ACC:  state_next = wrs_pkg::ST_VDIV;
            wrs_pkg::ST_VDIV: if (step_reg == 8'd129) state_next = wrs_pkg::ST_SQRT;
            wrs_pkg::ST_SQRT: if (step_reg == 8'd33) state_next = wrs_pkg::ST_OUT;
            wrs_pkg::ST_OUT:  state_next = wrs_pkg::ST_IDLE;
            default:          state_next = wrs_pkg::ST_IDLE;
        endcase
    end

    // control and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            least_reg     <= '0;
            greatest_reg  <= '0;
            seen_reg      <= 1'b0;
            mean_reg      <= '0;
            dev_reg       <= '0;
            wsum_reg      <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                wrs_pkg::ST_IDLE:
                begin
                    step_reg <= '0;
                    if (accept)
                    begin
                        if (in_data.cmd == wrs_pkg::CMD_CLEAR)
                        begin
                            least_reg    <= '0;
                            greatest_reg <= '0;
                            seen_reg     <= 1'b0;
                            mean_reg     <= '0;
                            dev_reg      <= '0;
                            wsum_reg     <= '0;
                        end
                        else
                        begin
                            if (cnt_reg != '1)
                                cnt_reg <= cnt_reg + 1'b1;
                            if (!in_data.invalid)
                            begin
                                if (!seen_reg || in_data.sample < least_reg)
                                    least_reg <= in_data.sample;
                                if (!seen_reg || in_data.sample > greatest_reg)
                                    greatest_reg <= in_data.sample;
                                seen_reg <= 1'b1;
                                if (in_data.weight != '0)
                                    wsum_reg <= wsum_add[48] ? '1 : wsum_add[47:0];
                            end
                        end
                    end
                end
                wrs_pkg::ST_MUL1:
                    step_reg <= (step_reg == 8'd32) ? 8'd0 : step_reg + 1'b1;
                wrs_pkg::ST_MDIV:
                begin
                    step_reg <= (step_reg == 8'd65) ? 8'd0 : step_reg + 1'b1;
                    if (step_reg == 8'd65)
                        mean_reg <= neg_reg ? mean_reg - rmag_reg : mean_reg + rmag_reg;
                end
                wrs_pkg::ST_MUL2:
                    step_reg <= (step_reg == 8'd81) ? 8'd0 : step_reg + 1'b1;
                wrs_pkg::ST_ACC:
                    dev_reg <= dev_add[64] ? '1 : dev_add[63:0];
                wrs_pkg::ST_VDIV:
                    step_reg <= (step_reg == 8'd129) ? 8'd0 : step_reg + 1'b1;
                wrs_pkg::ST_SQRT:
                    step_reg <= (step_reg == 8'd33) ? 8'd0 : step_reg + 1'b1;
                wrs_pkg::ST_OUT:
                    out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // serial datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            wrs_pkg::ST_IDLE:
                if (accept)
                begin
                    w_reg     <= in_data.weight;
                    neg_reg   <= q_c[32];
                    qmag_reg  <= qmag_c;
                    wold_reg  <= wsum_reg;
                    acc_reg   <= '0;
                    mcand_reg <= {95'd0, qmag_c};
                    shf_reg   <= {96'd0, in_data.weight};
                end
            wrs_pkg::ST_MUL1:
            begin
                // qmag * w, one multiplier bit per cycle
                if (step_reg < 8'd32)
                begin
                    if (shf_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg <= {mcand_reg[126:0], 1'b0};
                    shf_reg   <= {1'b0, shf_reg[127:1]};
                end
                else
                begin
                    shf_reg <= {acc_reg[63:0], 64'd0};
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
            end
            wrs_pkg::ST_MDIV:
            begin
                // (qmag*w) / S, restoring, one bit per cycle
                if (step_reg < 8'd64)
                begin
                    shf_reg <= {shf_reg[126:0], 1'b0};
                    if (rem_sh >= {1'b0, wsum_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, wsum_reg};
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                end
                else if (step_reg == 8'd64)
                begin
                    rmag_reg <= quo_reg[31:0];
                end
                else
                begin
                    // seed second multiply: rmag * qmag
                    acc_reg   <= '0;
                    mcand_reg <= {95'd0, qmag_reg};
                    shf_reg   <= {96'd0, rmag_reg};
                end
            end
            wrs_pkg::ST_MUL2:
            begin
                // first build rmag*qmag, then multiply it by W (the old weight sum)
                if (step_reg < 8'd32 || (step_reg > 8'd32 && step_reg <= 8'd80))
                begin
                    if (shf_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg <= {mcand_reg[126:0], 1'b0};
                    shf_reg   <= {1'b0, shf_reg[127:1]};
                end
                else if (step_reg == 8'd32)
                begin
                    acc_reg   <= '0;
                    mcand_reg <= {64'd0, acc_reg[63:0]};
                    shf_reg   <= {80'd0, wold_reg};
                end
            end
            wrs_pkg::ST_ACC:
            begin
                acc_reg <= acc_reg;
            end
            wrs_pkg::ST_VDIV:
            begin
                // v = dev * 2^F2 / wsum, 128 steps, quotient saturates
                if (step_reg == 8'd0)
                begin
                    shf_reg  <= {64'd0, dev_reg} << F2;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    over_reg <= 1'b0;
                end
                else if (step_reg <= 8'd128)
                begin
                    shf_reg <= {shf_reg[126:0], 1'b0};
                    if (rem_sh >= {1'b0, wsum_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, wsum_reg};
                        if (step_reg <= 8'd64)
                            over_reg <= 1'b1;
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                end
                else
                begin
                    sq_v_reg   <= (wsum_reg == '0) ? 64'd0 : (over_reg ? '1 : quo_reg);
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                end
            end
            wrs_pkg::ST_SQRT:
            begin
                if (step_reg < 8'd32)
                begin
                    if (sq_v_reg >= sq_res_reg + sq_bit_reg)
                    begin
                        sq_v_reg   <= sq_v_reg - (sq_res_reg + sq_bit_reg);
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_reg <= sq_res_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
            end
            wrs_pkg::ST_OUT:
            begin
                out_reg.min_value    <= least_reg;
                out_reg.max_value    <= greatest_reg;
                out_reg.range_known  <= seen_reg;
                out_reg.mean_value   <= mean_reg;
                out_reg.std_dev      <= sq_res_reg[31:0];
                out_reg.weight_total <= wsum_reg;
                out_reg.sample_count <= (cnt_reg > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                        : 32'(cnt_reg);
            end
            default: ;
        endcase
    end

endmodule

/* src/wrs_checker.sv */
// ----------------------------------------------------------------------------
// wrs_port_checker
// port-level checks for the weighted running statistics block
// ----------------------------------------------------------------------------
module wrs_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input wrs_pkg::wrs_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input wrs_pkg::wrs_out_t out_data
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // no new item while one is in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // min and max read zero while the range is unknown
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.range_known == 1'b0 |->
            out_data.min_value == '0 && out_data.max_value == '0)
        else $error("range not zero while unknown");

    // std dev zero when no weight
    a_std: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.weight_total == '0 |-> out_data.std_dev == '0)
        else $error("std dev nonzero with no weight");

endmodule

bind weighted_running_statistics wrs_port_checker u_wrs_checker (.*);

/* tb/wrs_checker.sv */
// ----------------------------------------------------------------------------
// wrs_checker
// watches both channels of the weighted running statistics block, predicts
// each result beat from the accepted input beats and compares field by field
// ----------------------------------------------------------------------------
module wrs_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  wrs_pkg::wrs_in_t   in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  wrs_pkg::wrs_out_t  out_data,
    output int                 errors,
    output int                 pending,
    output int                 adds_seen,
    output int                 clears_seen
);

    logic signed [31:0] lo_sample;
    logic signed [31:0] hi_sample;
    logic               seen;
    logic signed [31:0] mean;
    logic        [63:0] dev_sum;
    logic        [47:0] w_sum;
    logic        [63:0] n_adds;
    wrs_pkg::wrs_out_t  stats_q[$];

    assign pending = stats_q.size();

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'h1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] spread_now();
        logic [127:0] num;
        logic [127:0] quo;
        logic [63:0]  v;
        if (w_sum == 0)
            return 0;
        num = {64'h0, dev_sum} << (2 * wrs_pkg::FRAC_BITS);
        quo = num / w_sum;
        v   = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
        return 32'(sqrt_floor(v));
    endfunction

    task automatic blend_in(input logic signed [63:0] s, input logic [63:0] w);
        logic [63:0]        total;
        logic signed [63:0] q;
        logic [63:0]        qmag;
        logic [63:0]        rmag;
        logic [127:0]       prod;
        logic [63:0]        inc;
        logic [64:0]        acc;
        total = {16'h0, w_sum} + w;
        if (total > 64'hFFFF_FFFF_FFFF)
            total = 64'hFFFF_FFFF_FFFF;
        q    = s - 64'(mean);
        qmag = (q < 0) ? 64'(-q) : 64'(q);
        rmag = (qmag * w) / total;
        mean = (q < 0) ? 32'(64'(mean) - rmag) : 32'(64'(mean) + rmag);
        prod = 128'(rmag * qmag) * 128'(w_sum);
        inc  = prod[63 + 2 * wrs_pkg::FRAC_BITS:2 * wrs_pkg::FRAC_BITS];
        if ((prod >> (64 + 2 * wrs_pkg::FRAC_BITS)) != 0)
            inc = 64'hFFFF_FFFF_FFFF_FFFF;
        acc     = {1'b0, dev_sum} + inc;
        dev_sum = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
        w_sum   = total[47:0];
    endtask

    task automatic take_beat(input wrs_pkg::wrs_in_t b);
        wrs_pkg::wrs_out_t r;
        if (b.cmd == wrs_pkg::CMD_CLEAR)
        begin
            lo_sample = 0; hi_sample = 0; seen = 0; mean = 0; dev_sum = 0; w_sum = 0;
            clears_seen++;
        end
        else
        begin
            adds_seen++;
            if (n_adds < (64'h1 << wrs_pkg::COUNT_BITS) - 1)
                n_adds++;
            if (!b.invalid)
            begin
                if (!seen)
                begin
                    lo_sample = b.sample; hi_sample = b.sample; seen = 1;
                end
                else
                begin
                    if (b.sample < lo_sample) lo_sample = b.sample;
                    if (b.sample > hi_sample) hi_sample = b.sample;
                end
                if (b.weight != 0)
                    blend_in(64'(b.sample), 64'(b.weight));
            end
        end
        r.min_value    = lo_sample;
        r.max_value    = hi_sample;
        r.range_known  = seen;
        r.mean_value   = mean;
        r.std_dev      = spread_now();
        r.weight_total = w_sum;
        r.sample_count = (n_adds > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n_adds[31:0];
        stats_q.push_back(r);
    endtask

    task automatic compare_beat(input wrs_pkg::wrs_out_t g);
        wrs_pkg::wrs_out_t e;
        if (stats_q.size() == 0)
        begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        e = stats_q.pop_front();
        if (g.min_value !== e.min_value)
        begin
            $error("min_value exp %0d got %0d", e.min_value, g.min_value); errors++;
        end
        if (g.max_value !== e.max_value)
        begin
            $error("max_value exp %0d got %0d", e.max_value, g.max_value); errors++;
        end
        if (g.range_known !== e.range_known)
        begin
            $error("range_known exp %0d got %0d", e.range_known, g.range_known); errors++;
        end
        if (g.mean_value !== e.mean_value)
        begin
            $error("mean_value exp %0d got %0d", e.mean_value, g.mean_value); errors++;
        end
        if (g.std_dev !== e.std_dev)
        begin
            $error("std_dev exp %0d got %0d", e.std_dev, g.std_dev); errors++;
        end
        if (g.weight_total !== e.weight_total)
        begin
            $error("weight_total exp %0d got %0d", e.weight_total, g.weight_total);
            errors++;
        end
        if (g.sample_count !== e.sample_count)
        begin
            $error("sample_count exp %0d got %0d", e.sample_count, g.sample_count);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0; adds_seen = 0; clears_seen = 0;
        lo_sample = 0; hi_sample = 0; seen = 0; mean = 0; dev_sum = 0; w_sum = 0;
        n_adds = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                compare_beat(out_data);
            if (in_valid && in_ready)
                take_beat(in_data);
        end
    end

endmodule

/* tb/tb_weighted_running_statistics.sv */
// ----------------------------------------------------------------------------
// tb_weighted_running_statistics
// directed and random add and clear beats with random idling on both sides
// and one long output hold-off; results are checked by wrs_checker
// ----------------------------------------------------------------------------
module tb_weighted_running_statistics;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    wrs_pkg::wrs_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    wrs_pkg::wrs_out_t out_data;
    int                errors;
    int                pending;
    int                adds_seen;
    int                clears_seen;
    int                beat_no;
    bit                calm;

    weighted_running_statistics i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    wrs_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .errors      (errors),
        .pending     (pending),
        .adds_seen   (adds_seen),
        .clears_seen (clears_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] pick_word();
        unique case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return 32'($urandom_range(0, 255)) << 16;
            5: return $urandom_range(0, 1023);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input logic c, input logic [31:0] s, input logic [31:0] w,
                             input logic inv);
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= '{cmd: c, sample: s, weight: w, invalid: inv};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beat_no++;
    endtask

    // receiver: random stall, one long hold-off, one calm stretch
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (beat_no == 60)
            begin
                out_ready <= 0;
                repeat (3000) @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    initial
    begin
        int          i;
        int          k;
        logic [31:0] s;
        logic [31:0] w;
        in_valid = 0;
        in_data  = '0;
        rst_n    = 0;
        beat_no  = 0;
        calm     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: empty reads, extremes, zero weight, invalid, clear
        send_beat(wrs_pkg::CMD_ADD, 32'h0, 32'h0, 1);
        send_beat(wrs_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_beat(wrs_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h0, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'h8000_0000, 32'h0, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'h1234_5678, 32'hFFFF_FFFF, 1);
        send_beat(wrs_pkg::CMD_CLEAR, 32'h0, 32'h0, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'h0001_0000, 32'h0001_0000, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'hFFFF_0000, 32'h0001_0000, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'h0003_0000, 32'h0002_0000, 0);
        send_beat(wrs_pkg::CMD_CLEAR, 32'h0, 32'h0, 0);
        // many maximum weights in a row with alternating extreme samples
        for (k = 0; k < 12; k++)
            send_beat(wrs_pkg::CMD_ADD, (k & 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                      32'hFFFF_FFFF, 0);
        send_beat(wrs_pkg::CMD_ADD, 32'h0, 32'h8000_0000, 0);
        for (i = 0; i < 450; i++)
        begin
            calm = (i >= 200 && i < 260);
            s = pick_word();
            w = pick_word();
            if ($urandom_range(0, 99) < 5)
                send_beat(wrs_pkg::CMD_CLEAR, s, w, 1'($urandom_range(0, 1)));
            else
                send_beat(wrs_pkg::CMD_ADD, s, w, $urandom_range(0, 99) < 10);
        end
        in_valid <= 0;
        calm = 0;
        k = 0;
        while (pending != 0 && k < 200000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (500) @(posedge clk);
        $display("covered %0d adds and %0d clears, %0d result beats outstanding",
                 adds_seen, clears_seen, pending);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("tb: failure");
        $finish;
    end

endmodule
